// ----- design/gqtl_pkg.sv -----
// Shared constants, glyph record and adder request types for the glyph quad layout block.
`default_nettype none
package gqtl_pkg;

	localparam int GLYPH_COUNT = 256;
	localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
	localparam int VERTS       = 6;

	localparam logic [7:0]  CODE_SPACE   = 8'd32;
	localparam logic [7:0]  CODE_NEWLINE = 8'd10;
	localparam logic [16:0] Q_ONE        = 17'd32768;

	localparam logic [0:0] REG_LINE_HEIGHT   = 1'd0;
	localparam logic [0:0] REG_FIXED_ADVANCE = 1'd1;

	localparam logic [1:0] ADD_RAW = 2'd0;
	localparam logic [1:0] ADD_S16 = 2'd1;
	localparam logic [1:0] ADD_U16 = 2'd2;

	typedef struct packed {
		logic [11:0] width;
		logic [11:0] adv_a;
		logic [11:0] adv_c;
		logic [15:0] x1;
		logic [15:0] x2;
		logic [15:0] y1;
		logic [15:0] y2;
	} glyph_rec_t;

	typedef struct packed {
		logic signed [16:0] a;
		logic signed [16:0] b;
		logic [1:0]         mode;
	} add_req_t;

endpackage
`default_nettype wire

// ----- design/gqtl_sat_add.sv -----
// Shared saturating adder used for every pen and vertex position sum.
`default_nettype none
module gqtl_sat_add
	import gqtl_pkg::*;
(
	input  wire add_req_t    req,
	output logic [15:0]      res
);

	logic signed [17:0] sum;

	always_comb begin
		sum = 18'(req.a) + 18'(req.b);
		case (req.mode)
			ADD_S16: begin
				if (sum > 18'sd32767) begin
					res = 16'h7FFF;
				end else if (sum < -18'sd32768) begin
					res = 16'h8000;
				end else begin
					res = sum[15:0];
				end
			end
			ADD_U16: begin
				if (sum > 18'sd65535) begin
					res = 16'hFFFF;
				end else if (sum < 18'sd0) begin
					res = 16'h0000;
				end else begin
					res = sum[15:0];
				end
			end
			default: begin
				res = sum[15:0];
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/gqtl_glyph_mem.sv -----
// Glyph table: record memory with registered read and per-entry valid flags.
`default_nettype none
module gqtl_glyph_mem
	import gqtl_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 we,
	input  wire [GLYPH_AW-1:0]  waddr,
	input  wire glyph_rec_t     wdata,
	input  wire                 re,
	input  wire [GLYPH_AW-1:0]  raddr,
	output glyph_rec_t          rdata,
	output logic                rvalid
);

	glyph_rec_t             mem_q [GLYPH_COUNT];
	logic [GLYPH_COUNT-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid <= valid_q[raddr];
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/glyph_quad_text_layout.sv -----
// Top level: sequencer for glyph quad text layout around one shared saturating adder.
//
//  channel  dir  handshake                 beat
//  in       in   in_valid / in_ready       one define or character item
//  out      out  out_valid / out_ready     one vertex
//  cfg      in   cfg_we                    one register write
//
// A define item writes the glyph table. A character item does lookup and step,
// then a drawn glyph two vertex sums, six out-stallable vertex beats and pen
// advance, a space only the advance, a newline lacking a valid glyph a line
// step, all sums through the one adder. in_ready is high only while idle.
// Reset clears pen and glyph valid flags, sets line height 16, fixed advance on.
`default_nettype none
module glyph_quad_text_layout
	import gqtl_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               kind,
	input  wire [7:0]         char_code,
	input  wire               start_text,
	input  wire [11:0]        glyph_width,
	input  wire signed [11:0] advance_a,
	input  wire signed [11:0] advance_c,
	input  wire [15:0]        tex_left,
	input  wire [15:0]        tex_right,
	input  wire [15:0]        tex_top,
	input  wire [15:0]        tex_bottom,
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [15:0] vertex_x,
	output logic [15:0]       vertex_y,
	output logic [15:0]       tex_u,
	output logic [15:0]       tex_v,
	output logic [2:0]        corner,
	output logic              last_vertex,
	input  wire               cfg_we,
	input  wire [0:0]         cfg_index,
	input  wire [11:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_XR   = 3'd2;
	localparam logic [2:0] ST_YH   = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_ADV  = 3'd5;
	localparam logic [2:0] ST_NL   = 3'd6;

	logic [2:0]  state_q;
	logic [7:0]  code_q;
	logic [2:0]  corner_q;
	logic [15:0] pen_x_q;
	logic [15:0] pen_y_q;
	logic [15:0] step_q;
	logic [15:0] xr_q;
	logic [15:0] yh_q;
	logic [11:0] line_height_q;
	logic        fixed_advance_q;

	logic        in_acc;
	logic        out_acc;
	logic        code_ok;
	logic        glyph_ok;
	logic        wr_en;
	glyph_rec_t  wr_rec;
	glyph_rec_t  rd_rec;
	logic        rd_valid;
	add_req_t    add_req;
	logic [15:0] add_res;
	logic        at_high;
	logic [15:0] u_src;
	logic [15:0] y_src;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign out_acc   = out_valid && out_ready;

	assign code_ok  = ({1'b0, char_code} < 9'(GLYPH_COUNT));
	assign wr_en    = in_acc && !kind && code_ok;
	assign wr_rec   = '{width: glyph_width, adv_a: advance_a, adv_c: advance_c,
		x1: tex_left, x2: tex_right, y1: tex_top, y2: tex_bottom};
	assign glyph_ok = rd_valid && ({1'b0, code_q} < 9'(GLYPH_COUNT));

	gqtl_glyph_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wr_en),
		.waddr  (char_code[GLYPH_AW-1:0]),
		.wdata  (wr_rec),
		.re     (in_acc && kind),
		.raddr  (char_code[GLYPH_AW-1:0]),
		.rdata  (rd_rec),
		.rvalid (rd_valid)
	);

	always_comb begin
		add_req = '{a: '0, b: '0, mode: ADD_RAW};
		case (state_q)
			ST_LOOK: begin
				if (glyph_ok) begin
					add_req.a = {{5{rd_rec.adv_c[11]}}, rd_rec.adv_c};
					if (fixed_advance_q) begin
						add_req.b = {{5{rd_rec.adv_a[11]}}, rd_rec.adv_a};
					end
				end
			end
			ST_XR: begin
				add_req = '{a: {pen_x_q[15], pen_x_q}, b: {5'b0, rd_rec.width},
					mode: ADD_S16};
			end
			ST_YH, ST_NL: begin
				add_req = '{a: {1'b0, pen_y_q}, b: {5'b0, line_height_q}, mode: ADD_U16};
			end
			ST_ADV: begin
				add_req = '{a: {pen_x_q[15], pen_x_q}, b: {step_q[15], step_q},
					mode: ADD_S16};
			end
			default: begin
				add_req = '{a: '0, b: '0, mode: ADD_RAW};
			end
		endcase
	end

	gqtl_sat_add u_add (
		.req (add_req),
		.res (add_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_height_q   <= 12'd16;
			fixed_advance_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_HEIGHT:   line_height_q   <= cfg_data;
				REG_FIXED_ADVANCE: fixed_advance_q <= cfg_data[0];
				default:           line_height_q   <= line_height_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			code_q   <= '0;
			corner_q <= '0;
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			step_q   <= '0;
			xr_q     <= '0;
			yh_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && kind) begin
						code_q  <= char_code;
						state_q <= ST_LOOK;
						if (start_text) begin
							pen_x_q <= '0;
							pen_y_q <= '0;
						end
					end
				end
				ST_LOOK: begin
					step_q <= add_res;
					if (code_q == CODE_SPACE) begin
						state_q <= ST_ADV;
					end else if (glyph_ok) begin
						state_q <= ST_XR;
					end else if (code_q == CODE_NEWLINE) begin
						state_q <= ST_NL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_XR: begin
					xr_q    <= add_res;
					state_q <= ST_YH;
				end
				ST_YH: begin
					yh_q     <= add_res;
					corner_q <= '0;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (corner_q == 3'(VERTS - 1)) begin
							state_q <= ST_ADV;
						end else begin
							corner_q <= corner_q + 3'd1;
						end
					end
				end
				ST_ADV: begin
					pen_x_q <= add_res;
					state_q <= ST_IDLE;
				end
				ST_NL: begin
					pen_y_q <= add_res;
					pen_x_q <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		at_high = (corner_q == 3'd0) || (corner_q == 3'd4) || (corner_q == 3'd5);
		u_src   = corner_q[0] ? rd_rec.x2 : rd_rec.x1;
		y_src   = at_high ? rd_rec.y2 : rd_rec.y1;
		vertex_x = corner_q[0] ? xr_q : pen_x_q;
		vertex_y = at_high ? yh_q : pen_y_q;
		tex_u    = ({1'b0, u_src} > Q_ONE) ? Q_ONE[15:0] : u_src;
		tex_v    = ({1'b0, y_src} > Q_ONE) ? 16'd0 : 16'(Q_ONE - {1'b0, y_src});
		corner      = corner_q;
		last_vertex = (corner_q == 3'(VERTS - 1));
	end

endmodule
`default_nettype wire
